FILE: design/bldc6s_pkg.sv
// Shared types, constants and table functions of the six-step commutation sequencer.
package bldc6s_pkg;

  localparam int unsigned LOOP_RATE_HZ     = 20000;
  localparam int unsigned WATCHDOG_PERIODS = 4;

  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned TICK_W   = 20;
  localparam int unsigned EDGE_W   = 4;
  localparam int unsigned STEP_W   = 3;
  localparam int unsigned RAMP_W   = 12;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned WD_W     = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // One microsecond period numerator scaled for the Q12.4 frequency format.
  localparam int unsigned PERIOD_NUM = 16_000_000;
  localparam int unsigned TPS_NUM    = 2 * 16 * LOOP_RATE_HZ;

  localparam int unsigned DIV_NW = $clog2(PERIOD_NUM + 1);
  localparam int unsigned DIV_DW = FREQ_W + 3;
  localparam int unsigned DIV_CW = $clog2(DIV_NW);

  localparam logic [FREQ_W-1:0]   START_FREQ_RST = 16'd160;
  localparam logic [FREQ_W-1:0]   MAX_FREQ_RST   = 16'd3200;
  localparam logic [RAMP_W-1:0]   RAMP_RST       = 12'd8;
  localparam logic [FRAC_W-1:0]   FRAC_RST       = 8'd128;
  localparam logic [EDGE_W-1:0]   HANDOVER_RST   = 4'd6;
  localparam logic [PERIOD_W-1:0] AVG_RST        =
    PERIOD_W'(PERIOD_NUM / (6 * 160));

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_ARM   = 2'd1;
  localparam logic [1:0] FUNC_ALIGN = 2'd2;
  localparam logic [1:0] FUNC_FORCE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIR       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HANDOVER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_FWD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_REV = 3'd7;

  localparam logic [1:0] DRV_OFF = 2'd0;
  localparam logic [1:0] DRV_SRC = 2'd1;
  localparam logic [1:0] DRV_SNK = 2'd2;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_PREP,
    ST_EXEC,
    ST_WRITE
  } seq_state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [TIME_W-1:0] now_us;
    logic              torque_req;
    logic              ramp_enable;
    logic              zcd_ready;
    logic              duty_ok;
    logic              zc_edge;
  } in_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_index;
    logic [1:0]          drive_a;
    logic [1:0]          drive_b;
    logic [1:0]          drive_c;
    logic [1:0]          floating_phase;
    logic                closed_loop;
    logic                stepped;
    logic                watchdog_fell_back;
    logic [FREQ_W-1:0]   open_freq;
    logic [PERIOD_W-1:0] step_period;
  } out_t;

  // Phase drive pattern of a step, packed as {A, B, C}.
  function automatic logic [5:0] step_drive(input logic [STEP_W-1:0] step);
    logic [5:0] d;
    unique case (step)
      3'd0:    d = {DRV_SRC, DRV_SNK, DRV_OFF};
      3'd1:    d = {DRV_SRC, DRV_OFF, DRV_SNK};
      3'd2:    d = {DRV_OFF, DRV_SRC, DRV_SNK};
      3'd3:    d = {DRV_SNK, DRV_SRC, DRV_OFF};
      3'd4:    d = {DRV_SNK, DRV_OFF, DRV_SRC};
      3'd5:    d = {DRV_OFF, DRV_SNK, DRV_SRC};
      default: d = {DRV_OFF, DRV_OFF, DRV_OFF};
    endcase
    return d;
  endfunction

  function automatic logic [1:0] step_float(input logic [STEP_W-1:0] step);
    logic [1:0] p;
    unique case (step) inside
      3'd0, 3'd3: p = PH_C;
      3'd1, 3'd4: p = PH_B;
      3'd2, 3'd5: p = PH_A;
      default:    p = PH_A;
    endcase
    return p;
  endfunction

endpackage

FILE: design/bldc6s_if.sv
// Valid/ready channel interfaces for the sequencer's tick input and its result output.
interface bldc6s_in_if import bldc6s_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bldc6s_out_if import bldc6s_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/bldc_six_step_commutation_sequencer.sv
// Six-step BLDC commutation sequencer: open-loop ramp, zero-crossing handover and closed loop.
//
// One input transaction on in_i is one control tick or one command (arm, align start,
// force open loop). Each transaction yields exactly one result transaction on out_o
// carrying the step, the phase drive pattern, the mode flags, the open-loop frequency
// and the filtered step period.
// The configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i
// and are expected to change only while no transaction is in flight.
// A transaction runs from acceptance through the divide phase and the multiply,
// preparation, update and write states until its result is offered; the next transaction
// can be accepted at the clock edge that ends the first cycle in which the result is
// offered. The shared bit-serial divider works out the ticks per step (or the default
// period on arm) at one quotient bit per cycle and then reports the quotient; a multiply
// step, a preparation step, an update step and the output load follow.
// in_i.ready is high only while the sequencer waits for work.
// The result sits in an output register; while the receiver stalls it is held and the
// sequencer accepts one more transaction, which then waits until the register frees.
// Reset puts all configuration registers and the motor state at their defaults and
// empties the output register; no result is pending after reset.
module bldc_six_step_commutation_sequencer import bldc6s_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bldc6s_in_if.sink             in_i,
  bldc6s_out_if.source          out_o
);

  seq_state_e state_q, state_d;

  logic                dir_q;
  logic [FREQ_W-1:0]   start_freq_q;
  logic [FREQ_W-1:0]   max_freq_q;
  logic [RAMP_W-1:0]   ramp_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [EDGE_W-1:0]   handover_q;
  logic [STEP_W-1:0]   align_fwd_q;
  logic [STEP_W-1:0]   align_rev_q;

  logic [STEP_W-1:0]   cur_step_q, cur_step_d;
  logic                closed_q, closed_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [FREQ_W-1:0]   olf_q, olf_d;
  logic [EDGE_W-1:0]   edge_q, edge_d;
  logic [PERIOD_W-1:0] avg_q, avg_d;
  logic [TIME_W-1:0]   last_q, last_d;
  logic                last_vld_q, last_vld_d;
  logic [TIME_W-1:0]   dl_q;
  logic                dl_vld_q, dl_vld_d;
  logic                stepped_q, stepped_d;
  logic                fell_q, fell_d;

  in_t                 in_q;
  logic [PERIOD_W-1:0] dly_q;
  logic [TIME_W-1:0]   diff_q;
  logic [PERIOD_W-1:0] filt_q;
  logic                wd_hit_q;
  out_t                out_q;
  logic                out_vld_q;

  logic                accept;
  logic                load;
  logic                div_done;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  logic [DIV_NW-1:0]   quot;

  logic [PERIOD_W+FRAC_W-1:0] prod;
  logic [PERIOD_W-1:0]        dly_eff;
  logic [PERIOD_W-1:0]        meas;
  logic [PERIOD_W+2:0]        filt_sum;
  logic [PERIOD_W+WD_W-1:0]   wd_lim;
  logic                       closed_tick;
  logic                       zc_arm;
  logic                       due;
  logic                       do_step;
  logic [TICK_W-1:0]          tick_inc;
  logic [FREQ_W:0]            ramp_sum;
  logic [EDGE_W-1:0]          edge_inc;
  logic [STEP_W-1:0]          align_sel;
  logic [5:0]                 drv;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign load        = (state_q == ST_WRITE) && (!out_vld_q || out_o.ready);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Arm needs the default period, every other transaction the ticks per step.
  always_comb begin
    if (in_i.data.func == FUNC_ARM) begin
      div_num = DIV_NW'(PERIOD_NUM);
      div_den = DIV_DW'({start_freq_q, 2'b00}) + DIV_DW'({start_freq_q, 1'b0});
    end else begin
      div_num = DIV_NW'(TPS_NUM) + DIV_NW'(olf_q);
      div_den = DIV_DW'({olf_q, 1'b0});
    end
  end

  bldc6s_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_MUL;
      ST_MUL:   state_d = ST_PREP;
      ST_PREP:  state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_WRITE;
      ST_WRITE: if (load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign closed_tick = (in_q.func == FUNC_TICK) && closed_q && in_q.zcd_ready;
  assign zc_arm      = closed_tick && in_q.zc_edge;

  always_comb begin
    prod     = avg_q * frac_q;
    dly_eff  = ((frac_q == '0) || (dly_q == '0)) ? PERIOD_W'(1) : dly_q;
    meas     = (diff_q[TIME_W-1:PERIOD_W] != '0) ? '1 : diff_q[PERIOD_W-1:0];
    filt_sum = {avg_q, 3'b000} - {3'b000, avg_q} + {3'b000, meas};
    wd_lim   = avg_q * WD_W'(WATCHDOG_PERIODS);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i.data;
    end
    if (state_q == ST_MUL) begin
      dly_q  <= prod[PERIOD_W+FRAC_W-1:FRAC_W];
      diff_q <= in_q.now_us - last_q;
    end
    if (state_q == ST_PREP) begin
      filt_q   <= filt_sum[PERIOD_W+2:3];
      wd_hit_q <= diff_q > TIME_W'(wd_lim);
    end
    if (load) begin
      out_q.step_index         <= cur_step_q;
      out_q.drive_a            <= drv[5:4];
      out_q.drive_b            <= drv[3:2];
      out_q.drive_c            <= drv[1:0];
      out_q.floating_phase     <= step_float(cur_step_q);
      out_q.closed_loop        <= closed_q;
      out_q.stepped            <= stepped_q;
      out_q.watchdog_fell_back <= fell_q;
      out_q.open_freq          <= olf_q;
      out_q.step_period        <= avg_q;
    end
  end

  assign drv = step_drive(cur_step_q);

  always_comb begin
    cur_step_d = cur_step_q;
    closed_d   = closed_q;
    tick_d     = tick_q;
    olf_d      = olf_q;
    edge_d     = edge_q;
    avg_d      = avg_q;
    last_d     = last_q;
    last_vld_d = last_vld_q;
    dl_vld_d   = dl_vld_q;
    stepped_d  = 1'b0;
    fell_d     = 1'b0;
    do_step    = 1'b0;
    due        = dl_vld_q && (in_q.now_us >= dl_q);
    tick_inc   = tick_q + 1'b1;
    ramp_sum   = {1'b0, olf_q} + (FREQ_W + 1)'(ramp_q);
    edge_inc   = (edge_q == '1) ? edge_q : edge_q + 1'b1;
    align_sel  = dir_q ? align_rev_q : align_fwd_q;

    unique case (in_q.func)
      FUNC_ARM: begin
        cur_step_d = '0;
        closed_d   = 1'b0;
        edge_d     = '0;
        tick_d     = '0;
        olf_d      = start_freq_q;
        avg_d      = (start_freq_q == '0) ? '1 : PERIOD_W'(quot);
        last_vld_d = 1'b0;
        dl_vld_d   = 1'b0;
      end
      FUNC_ALIGN: begin
        cur_step_d = (align_sel > STEP_LAST) ? '0 : align_sel;
        closed_d   = 1'b0;
        edge_d     = '0;
        tick_d     = '0;
        olf_d      = start_freq_q;
        last_vld_d = 1'b0;
        dl_vld_d   = 1'b0;
      end
      FUNC_FORCE: begin
        closed_d = 1'b0;
        edge_d   = '0;
        tick_d   = '0;
        olf_d    = start_freq_q;
        dl_vld_d = 1'b0;
      end
      FUNC_TICK: begin
        if (closed_q && in_q.zcd_ready) begin
          if (due) begin
            dl_vld_d = 1'b0;
            do_step  = 1'b1;
          end else if (last_vld_q && wd_hit_q) begin
            closed_d = 1'b0;
            edge_d   = '0;
            tick_d   = '0;
            dl_vld_d = 1'b0;
            fell_d   = 1'b1;
          end
        end else begin
          closed_d = 1'b0;
          if (in_q.torque_req && (olf_q != '0) && (quot != '0)) begin
            if (DIV_NW'(tick_inc) >= quot) begin
              tick_d  = '0;
              do_step = 1'b1;
              if (in_q.ramp_enable) begin
                olf_d = (ramp_sum > {1'b0, max_freq_q}) ? max_freq_q : ramp_sum[FREQ_W-1:0];
              end
            end else begin
              tick_d = tick_inc;
            end
          end
          if (in_q.zcd_ready && in_q.duty_ok && in_q.zc_edge) begin
            edge_d = edge_inc;
            if (edge_inc >= handover_q) begin
              closed_d = 1'b1;
              tick_d   = '0;
              dl_vld_d = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (do_step) begin
      stepped_d  = 1'b1;
      if (last_vld_q) begin
        avg_d = filt_q;
      end
      last_d     = in_q.now_us;
      last_vld_d = 1'b1;
      if (dir_q) begin
        cur_step_d = (cur_step_q == '0) ? STEP_LAST : cur_step_q - 1'b1;
      end else begin
        cur_step_d = (cur_step_q == STEP_LAST) ? '0 : cur_step_q + 1'b1;
      end
    end
    if ((in_q.func == FUNC_TICK) && !closed_q && closed_d) begin
      last_d     = in_q.now_us;
      last_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q        <= 1'b0;
      start_freq_q <= START_FREQ_RST;
      max_freq_q   <= MAX_FREQ_RST;
      ramp_q       <= RAMP_RST;
      frac_q       <= FRAC_RST;
      handover_q   <= HANDOVER_RST;
      align_fwd_q  <= '0;
      align_rev_q  <= '0;
      cur_step_q   <= '0;
      closed_q     <= 1'b0;
      tick_q       <= '0;
      olf_q        <= START_FREQ_RST;
      edge_q       <= '0;
      avg_q        <= AVG_RST;
      last_q       <= '0;
      last_vld_q   <= 1'b0;
      dl_q         <= '0;
      dl_vld_q     <= 1'b0;
      stepped_q    <= 1'b0;
      fell_q       <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIR:       dir_q        <= cfg_data_i[0];
          CFG_START:     start_freq_q <= cfg_data_i;
          CFG_MAX:       max_freq_q   <= cfg_data_i;
          CFG_RAMP:      ramp_q       <= cfg_data_i[RAMP_W-1:0];
          CFG_FRAC:      frac_q       <= cfg_data_i[FRAC_W-1:0];
          CFG_HANDOVER:  handover_q   <= cfg_data_i[EDGE_W-1:0];
          CFG_ALIGN_FWD: align_fwd_q  <= cfg_data_i[STEP_W-1:0];
          CFG_ALIGN_REV: align_rev_q  <= cfg_data_i[STEP_W-1:0];
        endcase
      end
      if ((state_q == ST_PREP) && zc_arm) begin
        dl_q     <= in_q.now_us + TIME_W'(dly_eff);
        dl_vld_q <= 1'b1;
      end
      if (state_q == ST_EXEC) begin
        cur_step_q <= cur_step_d;
        closed_q   <= closed_d;
        tick_q     <= tick_d;
        olf_q      <= olf_d;
        edge_q     <= edge_d;
        avg_q      <= avg_d;
        last_q     <= last_d;
        last_vld_q <= last_vld_d;
        dl_vld_q   <= dl_vld_d;
        stepped_q  <= stepped_d;
        fell_q     <= fell_d;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_step_q <= STEP_LAST)
    else $error("commutation step left the six-step range");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_step_xor_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.stepped && out_q.watchdog_fell_back))
    else $error("result reports both a step and a watchdog fallback");

  a_fall_is_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.watchdog_fell_back) |-> !out_q.closed_loop)
    else $error("watchdog fallback left the sequencer in closed loop");
`endif

endmodule

FILE: design/bldc6s_div.sv
// Restoring radix-2 divider that retires one quotient bit per clock cycle.
module bldc6s_div import bldc6s_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW:0]   rem_q, rem_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW+1:0] trial;

  always_comb begin
    shifted = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    if (trial[DIV_DW+1]) begin
      rem_d = shifted;
    end else begin
      rem_d = trial[DIV_DW:0];
    end
    quo_d = {quo_q[DIV_NW-2:0], ~trial[DIV_DW+1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
